// ----- src/line_command_dispatcher_defines.svh -----
// Assertion macros shared by the line command dispatcher RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LINE_COMMAND_DISPATCHER_DEFINES_SVH
`define LINE_COMMAND_DISPATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line_command_dispatcher: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line_command_dispatcher: next-cycle check failed");

`endif

// ----- src/lcd_pkg.sv -----
// Shared types, character constants and helper functions for the
// line command dispatcher. Depends on nothing.
package lcd_pkg;

  localparam int LINE_DEPTH_DEFAULT = 64;
  localparam int COMMAND_SLOTS = 62;
  localparam int SLOT_W = $clog2(COMMAND_SLOTS);

  localparam logic [7:0] CHAR_PERCENT = 8'd37;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] SLOT_UPPER_BASE = 8'd10;
  localparam logic [7:0] SLOT_LOWER_BASE = 8'd36;

  localparam logic [7:0] REG_NAME_LEN = 8'd1;
  localparam logic [7:0] UART_SOURCE_RESET = 8'd255;
  localparam logic [7:0] NO_HANDLER = 8'd0;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_CANNOT  = 2'd1,
    KIND_INVALID = 2'd2
  } kind_t;

  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_KEY      = 1'b1
  } op_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] handler_id;
    logic [7:0] data_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        id;
  } tbl_wr_t;

  function automatic logic is_alnum(input logic [7:0] ch);
    return (ch >= CHAR_ZERO && ch <= CHAR_NINE) ||
           (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ||
           (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z);
  endfunction

  // Meaningful only for alphanumeric letters.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] ch);
    logic [7:0] d;
    if (ch >= CHAR_LOWER_A) begin
      d = ch - CHAR_LOWER_A + SLOT_LOWER_BASE;
    end else if (ch >= CHAR_UPPER_A) begin
      d = ch - CHAR_UPPER_A + SLOT_UPPER_BASE;
    end else begin
      d = ch - CHAR_ZERO;
    end
    return d[SLOT_W-1:0];
  endfunction

endpackage

// ----- src/line_command_dispatcher.sv -----
// Line command dispatcher. Registration items and plain keys leave the block
// idle, so they never hold off the next item. An Enter whose line is empty,
// overflowed or does not start with '%' and a letter goes straight to ST_ERR
// and loads its single error result from there once the output register is
// free. An Enter that fails the command table lookup (no handler, or the target
// not ready) loads it from ST_ERR too, after ST_CHECK, where the table read is
// back. An Enter with a live handler goes from ST_CHECK, which also issues the
// first line memory read, to ST_EMIT. It then loads the line's bytes after the
// '%' at one item per cycle while the output is not stalled. The single read
// port of the line memory sets that pace. No new item is taken until the last
// result of an Enter is loaded. The command table needs no clearing pass after
// reset.
module line_command_dispatcher #(
  parameter int LINE_DEPTH = lcd_pkg::LINE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic       operation,
  input  logic [7:0] source_id,
  input  logic [7:0] payload_length,
  input  logic [7:0] char_code,
  input  logic       target_ready,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] result_kind,
  output logic [7:0] handler_id,
  output logic [7:0] data_byte,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import lcd_pkg::*;

  `include "line_command_dispatcher_defines.svh"

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int FW = $clog2(LINE_DEPTH + 2);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_ERR   = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [7:0]    uart_source_id;
  logic [FW-1:0] fill;
  logic [FW-1:0] line_len;
  logic [FW-1:0] idx;
  logic [FW-1:0] idx_inc;
  logic [7:0]    first_byte;
  logic [7:0]    letter;
  logic          ready_q;
  logic [7:0]    handler;
  kind_t         err_kind;

  logic          cmd_accept;
  logic          reg_ok;
  logic          key_ok;
  logic          key_enter;
  logic          key_store;
  logic          line_bad;
  logic          line_nocmd;
  logic          emit_last;

  tbl_wr_t       tbl_wr;
  logic          tbl_rd_en;
  logic [7:0]    tbl_id;

  logic          buf_rd_en;
  logic [AW-1:0] buf_rd_addr;
  logic [7:0]    buf_rd_data;

  logic          res_load;
  result_t       res_next;
  result_t       res_data;
  logic          res_free;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != ST_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;

  assign reg_ok = cmd_accept && (operation == OP_REGISTER) &&
                  (payload_length == REG_NAME_LEN) && is_alnum(char_code);
  assign key_ok = cmd_accept && (operation == OP_KEY) && (source_id == uart_source_id);
  assign key_enter = key_ok && (char_code == CHAR_LF || char_code == CHAR_CR);
  assign key_store = key_ok && !key_enter;

  // Overflowed lines sit at LINE_DEPTH + 1, above any real fill.
  assign line_bad = (fill == '0) || (fill > FW'(LINE_DEPTH)) || (first_byte != CHAR_PERCENT);
  assign line_nocmd = (fill < FW'(2)) || !is_alnum(letter);

  assign idx_inc = idx + FW'(1);
  assign emit_last = (idx_inc == line_len);

  assign tbl_wr.en = reg_ok;
  assign tbl_wr.slot = slot_of(char_code);
  assign tbl_wr.id = source_id;

  // Registrations and lookups are separate items, so a write always lands
  // at an earlier edge than any read that could see it.
  lcd_cmd_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (tbl_wr),
    .rd_en   (tbl_rd_en),
    .rd_slot (slot_of(letter)),
    .rd_id   (tbl_id)
  );

  lcd_line_buf #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (key_store && (fill < FW'(LINE_DEPTH))),
    .wr_addr (fill[AW-1:0]),
    .wr_data (char_code),
    .rd_en   (buf_rd_en),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  lcd_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .load_data (res_next),
    .stall     (res_stall),
    .valid     (res_valid),
    .data      (res_data),
    .free      (res_free)
  );

  assign result_kind = res_data.kind;
  assign handler_id = res_data.handler_id;
  assign data_byte = res_data.data_byte;
  assign last = res_data.last;

  always_comb begin
    state_next = state;
    tbl_rd_en = 1'b0;
    buf_rd_en = 1'b0;
    buf_rd_addr = idx_inc[AW-1:0];
    res_load = 1'b0;
    res_next = '{kind: err_kind, handler_id: NO_HANDLER, data_byte: 8'd0, last: 1'b1};
    unique case (state)
      ST_IDLE: begin
        if (key_enter) begin
          if (line_bad || line_nocmd) begin
            state_next = ST_ERR;
          end else begin
            tbl_rd_en = 1'b1;
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (tbl_id == NO_HANDLER || !ready_q) begin
          state_next = ST_ERR;
        end else begin
          buf_rd_en = 1'b1;
          buf_rd_addr = AW'(1);
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_free) begin
          res_load = 1'b1;
          res_next = '{kind: KIND_PAYLOAD, handler_id: handler,
                       data_byte: buf_rd_data, last: emit_last};
          if (emit_last) begin
            state_next = ST_IDLE;
          end else begin
            buf_rd_en = 1'b1;
          end
        end
      end
      ST_ERR: begin
        if (res_free) begin
          res_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0;
      uart_source_id <= UART_SOURCE_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        uart_source_id <= cfg_data;
      end
      if (key_enter) begin
        fill <= '0;
      end else if (key_store) begin
        if (fill < FW'(LINE_DEPTH)) begin
          fill <= fill + FW'(1);
        end else begin
          fill <= FW'(LINE_DEPTH + 1);
        end
      end
    end
  end

  // Payload registers: the first two bytes of the line are mirrored for the
  // Enter decision, the rest are per-command working values.
  always_ff @(posedge clk) begin
    if (key_store && fill == FW'(0)) begin
      first_byte <= char_code;
    end
    if (key_store && fill == FW'(1)) begin
      letter <= char_code;
    end
    if (key_enter) begin
      line_len <= fill;
      ready_q <= target_ready;
      err_kind <= line_bad ? KIND_INVALID : KIND_CANNOT;
    end
    if (state == ST_CHECK) begin
      handler <= tbl_id;
      idx <= FW'(1);
      err_kind <= KIND_CANNOT;
    end
    if (state == ST_EMIT && res_free && !emit_last) begin
      idx <= idx_inc;
    end
  end

  `LCD_ASSERT_IMPLY(a_err_single, clk, rst, res_valid && (result_kind != KIND_PAYLOAD),
                    last && (handler_id == NO_HANDLER) && (data_byte == 8'd0))
  `LCD_ASSERT_IMPLY(a_payload_handler, clk, rst, res_valid && (result_kind == KIND_PAYLOAD),
                    handler_id != NO_HANDLER)
  `LCD_ASSERT_IMPLY(a_fill_range, clk, rst, 1'b1, fill <= FW'(LINE_DEPTH + 1))
  `LCD_ASSERT_NEXT(a_enter_clears, clk, rst, key_enter, fill == '0)

endmodule

// ----- src/lcd_cmd_table.sv -----
// Command table: one handler id per alphanumeric letter, in a synchronous
// memory with per-slot valid bits so that reset reads as "no handler".
// Depends on lcd_pkg.
module lcd_cmd_table (
  input  logic                      clk,
  input  logic                      rst,
  input  lcd_pkg::tbl_wr_t          wr,
  input  logic                      rd_en,
  input  logic [lcd_pkg::SLOT_W-1:0] rd_slot,
  output logic [7:0]                rd_id
);
  import lcd_pkg::*;

  logic [7:0]               mem [COMMAND_SLOTS];
  logic [COMMAND_SLOTS-1:0] slot_valid;
  logic [7:0]               rd_data;
  logic                     rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot] <= wr.id;
    end
    if (rd_en) begin
      rd_data <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        slot_valid[wr.slot] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= slot_valid[rd_slot];
      end
    end
  end

  assign rd_id = rd_valid ? rd_data : NO_HANDLER;

endmodule

// ----- src/lcd_line_buf.sv -----
// Line buffer memory: one write port for typed keys, one registered read
// port for replaying the line. Depends on lcd_pkg.
module lcd_line_buf #(
  parameter int LINE_DEPTH = lcd_pkg::LINE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
  input  logic [7:0]                    wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
  output logic [7:0]                    rd_data
);
  import lcd_pkg::*;

  logic [7:0] mem [LINE_DEPTH];

  // Read data holds between reads so that a stalled output can wait on it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/lcd_result_reg.sv -----
// Output register for result items with a valid/stall handshake.
// Depends on lcd_pkg.
module lcd_result_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  lcd_pkg::result_t load_data,
  input  logic             stall,
  output logic             valid,
  output lcd_pkg::result_t data,
  output logic             free
);
  import lcd_pkg::*;

  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

// ----- tb/line_command_dispatcher_test.sv -----
// Self-checking testbench for line_command_dispatcher: a directed table, then random lines
// and noise under random sender gaps and receiver stalls, checked against a predictor.
// Depends on lcd_pkg and the line_command_dispatcher RTL.
`timescale 1ns / 100ps

module line_command_dispatcher_test;
  import lcd_pkg::*;

  localparam int LINE_BYTES = LINE_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 80;
  localparam int TIMEOUT_NS = 600_000 * 12;
  localparam int DIRECTED_ROWS = 25;
  localparam int PHASE_ITEMS = 22;

  typedef struct packed {
    op_t        op;
    logic [7:0] src;
    logic [7:0] len;
    logic [7:0] ch;
    logic       ready;
    logic       fixed;
    kind_t      fixed_kind;
  } script_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  logic       operation = 1'b0;
  logic [7:0] source_id = 8'd0;
  logic [7:0] payload_length = 8'd0;
  logic [7:0] char_code = 8'd0;
  logic       target_ready = 1'b0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [1:0] result_kind;
  logic [7:0] handler_id;
  logic [7:0] data_byte;
  logic       last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  // Predictor state.
  logic [7:0] handler_tbl [COMMAND_SLOTS];
  logic [7:0] line_mem [LINE_BYTES];
  int         line_fill;
  logic [7:0] key_source;
  result_t    dispatch_out [LINE_BYTES];

  result_t    awaited_dispatch [$];
  result_t    oldest;
  bit         failed = 1'b0;
  int         counted = 0;
  int         burst_left = 0;
  int         stall_ticks = 0;
  int         stall_mode = 0;

  // Directed rows: the expected result is given only for the obvious error lines.
  script_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_KEY,      8'd255, 8'd1, CHAR_LF,      1'b1, 1'b1, KIND_INVALID},
    '{OP_KEY,      8'd255, 8'd1, CHAR_PERCENT, 1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd0, CHAR_CR,      1'b1, 1'b1, KIND_CANNOT},
    '{OP_KEY,      8'd255, 8'd1, CHAR_UPPER_A, 1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, CHAR_LF,      1'b1, 1'b1, KIND_INVALID},
    '{OP_REGISTER, 8'd1,   8'd1, CHAR_LOWER_A, 1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_REGISTER, 8'h42,  8'd2, CHAR_UPPER_Z, 1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_REGISTER, 8'h43,  8'd1, 8'd35,        1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_REGISTER, 8'd255, 8'd1, CHAR_ZERO,    1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_REGISTER, 8'h80,  8'd1, CHAR_LOWER_Z, 1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, CHAR_PERCENT, 1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, CHAR_LOWER_A, 1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, 8'hFF,        1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, 8'h00,        1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, CHAR_LF,      1'b1, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, CHAR_PERCENT, 1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, CHAR_UPPER_Z, 1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, CHAR_LF,      1'b1, 1'b1, KIND_CANNOT},
    '{OP_KEY,      8'd255, 8'd1, CHAR_PERCENT, 1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, CHAR_LOWER_Z, 1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, CHAR_CR,      1'b0, 1'b1, KIND_CANNOT},
    '{OP_KEY,      8'd0,   8'd1, CHAR_PERCENT, 1'b1, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, CHAR_PERCENT, 1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, 8'd35,        1'b0, 1'b0, KIND_PAYLOAD},
    '{OP_KEY,      8'd255, 8'd1, CHAR_CR,      1'b1, 1'b1, KIND_CANNOT}
  };

  line_command_dispatcher DUT (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .operation      (operation),
    .source_id      (source_id),
    .payload_length (payload_length),
    .char_code      (char_code),
    .target_ready   (target_ready),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .result_kind    (result_kind),
    .handler_id     (handler_id),
    .data_byte      (data_byte),
    .last           (last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic bit letter_ok(input logic [7:0] ch);
    return (ch >= CHAR_ZERO && ch <= CHAR_NINE) || (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ||
           (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z);
  endfunction

  function automatic int letter_slot(input logic [7:0] ch);
    if (ch <= CHAR_NINE) return int'(ch) - int'(CHAR_ZERO);
    if (ch <= CHAR_UPPER_Z) return int'(ch) - int'(CHAR_UPPER_A) + int'(SLOT_UPPER_BASE);
    return int'(ch) - int'(CHAR_LOWER_A) + int'(SLOT_LOWER_BASE);
  endfunction

  // Applies one item to the predicted state. Returns the number of results placed in
  // dispatch_out, or -1 when the block ignores the item.
  function automatic int run_dispatch(input op_t op, input logic [7:0] src,
                                      input logic [7:0] len, input logic [7:0] ch,
                                      input logic ready);
    int         n;
    logic [7:0] id;
    if (op == OP_REGISTER) begin
      if (len != REG_NAME_LEN || !letter_ok(ch)) return -1;
      handler_tbl[letter_slot(ch)] = src;
      return 0;
    end
    if (src != key_source) return -1;
    if (ch != CHAR_LF && ch != CHAR_CR) begin
      if (line_fill < LINE_BYTES) begin
        line_mem[line_fill] = ch;
        line_fill++;
      end else begin
        line_fill = LINE_BYTES + 1;
      end
      return 0;
    end
    n = line_fill;
    line_fill = 0;
    if (n == 0 || n > LINE_BYTES || line_mem[0] != CHAR_PERCENT) begin
      dispatch_out[0] = '{KIND_INVALID, NO_HANDLER, 8'd0, 1'b1};
      return 1;
    end
    if (n < 2 || !letter_ok(line_mem[1])) begin
      dispatch_out[0] = '{KIND_CANNOT, NO_HANDLER, 8'd0, 1'b1};
      return 1;
    end
    id = handler_tbl[letter_slot(line_mem[1])];
    if (id == NO_HANDLER || !ready) begin
      dispatch_out[0] = '{KIND_CANNOT, NO_HANDLER, 8'd0, 1'b1};
      return 1;
    end
    for (int i = 1; i < n; i++) dispatch_out[i-1] = '{KIND_PAYLOAD, id, line_mem[i], i + 1 == n};
    return n - 1;
  endfunction

  function automatic logic [7:0] pick_letter();
    int idx;
    idx = $urandom_range(COMMAND_SLOTS - 1, 0);
    if (idx < 10) return 8'(int'(CHAR_ZERO) + idx);
    if (idx < 36) return 8'(int'(CHAR_UPPER_A) + (idx - 10));
    return 8'(int'(CHAR_LOWER_A) + (idx - 36));
  endfunction

  // Presents one item, waits for it to be taken, records its expected results and then
  // either keeps valid high for the next item or opens a gap.
  task automatic issue(input op_t op, input logic [7:0] src, input logic [7:0] len,
                       input logic [7:0] ch, input logic ready, input bit fixed,
                       input kind_t fixed_kind);
    int produced;
    cmd_valid <= 1'b1;
    operation <= op;
    source_id <= src;
    payload_length <= len;
    char_code <= ch;
    target_ready <= ready;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    produced = run_dispatch(op, src, len, ch, ready);
    if (fixed) begin
      awaited_dispatch.push_back('{fixed_kind, NO_HANDLER, 8'd0, 1'b1});
    end else begin
      for (int i = 0; i < produced; i++) awaited_dispatch.push_back(dispatch_out[i]);
    end
    if (produced >= 0) counted++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(9, 0) == 0) ? 150 : $urandom_range(20, 0);
    end
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (awaited_dispatch.size() != 0) @(posedge clk);
  endtask

  task automatic set_key_source(input logic [7:0] value);
    wait_drained();
    // Plain keys give no result, so give the last one time to settle.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    key_source = value;
  endtask

  task automatic send_line();
    logic [7:0] letter;
    logic [7:0] id;
    logic [7:0] b;
    int         extra;
    int         r;
    letter = pick_letter();
    if ($urandom_range(9, 0) < 6) begin
      id = ($urandom_range(7, 0) == 0) ? NO_HANDLER : 8'($urandom_range(255, 1));
      issue(OP_REGISTER, id, REG_NAME_LEN, letter, 1'($urandom_range(1, 0)), 1'b0,
            KIND_PAYLOAD);
    end
    issue(OP_KEY, key_source, 8'($urandom_range(255, 0)), CHAR_PERCENT,
          1'($urandom_range(1, 0)), 1'b0, KIND_PAYLOAD);
    issue(OP_KEY, key_source, 8'($urandom_range(255, 0)), letter,
          1'($urandom_range(1, 0)), 1'b0, KIND_PAYLOAD);
    // Mostly short lines; a few fill the buffer exactly or overflow it.
    r = $urandom_range(99, 0);
    if (r < 88) extra = $urandom_range(5, 0);
    else if (r < 95) extra = $urandom_range(61, 6);
    else if (r < 97) extra = LINE_BYTES - 2;
    else extra = $urandom_range(LINE_BYTES + 2, LINE_BYTES - 1);
    for (int i = 0; i < extra; i++) begin
      do b = 8'($urandom_range(255, 0)); while (b == CHAR_LF || b == CHAR_CR);
      issue(OP_KEY, key_source, 8'($urandom_range(255, 0)), b, 1'($urandom_range(1, 0)),
            1'b0, KIND_PAYLOAD);
    end
    issue(OP_KEY, key_source, 8'($urandom_range(255, 0)),
          $urandom_range(1, 0) ? CHAR_LF : CHAR_CR, $urandom_range(9, 0) != 0, 1'b0,
          KIND_PAYLOAD);
  endtask

  task automatic send_noise();
    logic [7:0] src;
    logic [7:0] len;
    logic [7:0] ch;
    int         r;
    src = $urandom_range(1, 0) ? key_source : 8'($urandom_range(255, 0));
    len = $urandom_range(1, 0) ? REG_NAME_LEN : 8'($urandom_range(255, 0));
    r = $urandom_range(19, 0);
    if (r < 5) ch = pick_letter();
    else if (r < 7) ch = $urandom_range(1, 0) ? CHAR_LF : CHAR_CR;
    else if (r < 9) ch = CHAR_PERCENT;
    else ch = 8'($urandom_range(255, 0));
    issue(op_t'($urandom_range(1, 0)), src, len, ch, 1'($urandom_range(1, 0)), 1'b0,
          KIND_PAYLOAD);
  endtask

  // The receiver stalls on its own schedule: never, at random, or on a fixed pattern.
  always @(posedge clk) begin
    stall_ticks++;
    if (stall_ticks % 200 == 0) stall_mode = $urandom_range(2, 0);
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(2, 0) == 0);
      default: res_stall <= (stall_ticks % 7 < 3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (awaited_dispatch.size() == 0) begin
        $error("unexpected result: kind %0d handler %0d data %0d last %0d", result_kind,
               handler_id, data_byte, last);
        failed = 1'b1;
      end else begin
        oldest = awaited_dispatch.pop_front();
        if (result_kind !== oldest.kind) begin
          $error("result_kind: expected %0d, actual %0d", oldest.kind, result_kind);
          failed = 1'b1;
        end
        if (handler_id !== oldest.handler_id) begin
          $error("handler_id: expected %0d, actual %0d", oldest.handler_id, handler_id);
          failed = 1'b1;
        end
        if (data_byte !== oldest.data_byte) begin
          $error("data_byte: expected %0d, actual %0d", oldest.data_byte, data_byte);
          failed = 1'b1;
        end
        if (last !== oldest.last) begin
          $error("last: expected %0d, actual %0d", oldest.last, last);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int goal;
    key_source = UART_SOURCE_RESET;
    line_fill = 0;
    for (int i = 0; i < COMMAND_SLOTS; i++) handler_tbl[i] = NO_HANDLER;
    for (int i = 0; i < LINE_BYTES; i++) line_mem[i] = 8'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      issue(directed_rows[i].op, directed_rows[i].src, directed_rows[i].len,
            directed_rows[i].ch, directed_rows[i].ready, directed_rows[i].fixed,
            directed_rows[i].fixed_kind);
    end
    // The sender holds off here until every result of the directed part is back.
    wait_drained();

    counted = 0;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 1) set_key_source(8'd0);
      else if (phase == 2) set_key_source(8'($urandom_range(254, 1)));
      else if (phase == 3) set_key_source(UART_SOURCE_RESET);
      goal = counted + PHASE_ITEMS;
      while (counted < goal) begin
        if ($urandom_range(29, 0) == 0) wait_drained();
        if ($urandom_range(9, 0) < 7) send_line();
        else send_noise();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
